### rtl/gdad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdad_pkg: shared types and constants for the date advance block
// Field widths, step limit, month codes, and the item and result bundles of the date logic.
// ----------------------------------------------------------------------------
package gdad_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned STEP_W  = 4;

  // largest step honored, larger requests saturate
  localparam int unsigned MAX_STEP = 15;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [YEAR_W-1:0] YEAR_MAX = '1;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [STEP_W-1:0]  step;
  } gdad_item_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               ovf;
    logic               bad;
  } gdad_res_t;

endpackage

### rtl/gdad_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdad_calc: combinational date advance
// Leap test, month length lookup, range check and one month rollover.
// ----------------------------------------------------------------------------
module gdad_calc (
  input  gdad_pkg::gdad_item_t item,
  output gdad_pkg::gdad_res_t  res
);

  // year = 4*m when divisible by 4; m / 25 via reciprocal 1311/2^15, multiplied back to test m % 25
  logic [9:0]  quarter;
  logic [20:0] q25_prod;
  logic [5:0]  q25;
  logic [9:0]  q25_back;
  logic        div4;
  logic        div100;
  logic        div400;
  logic        leap;
  logic [4:0]  mlen;
  logic        bad;
  logic [4:0]  step;
  logic [5:0]  sum;
  logic        roll;

  always_comb begin
    quarter  = item.year[11:2];
    q25_prod = 21'(quarter) * 21'd1311;
    q25      = q25_prod[20:15];
    q25_back = (10'(q25) << 4) + (10'(q25) << 3) + 10'(q25);
    div4     = (item.year[1:0] == 2'b00);
    div100   = div4 && (q25_back == quarter);
    div400   = div100 && (quarter[1:0] == 2'b00);
    leap     = div4 && (!div100 || div400);

    case (item.month)
      gdad_pkg::MONTH_FEB: mlen = leap ? 5'd29 : 5'd28;
      gdad_pkg::MONTH_APR,
      gdad_pkg::MONTH_JUN,
      gdad_pkg::MONTH_SEP,
      gdad_pkg::MONTH_NOV: mlen = 5'd30;
      default:             mlen = 5'd31;
    endcase

    bad = (item.month < gdad_pkg::MONTH_JAN) || (item.month > gdad_pkg::MONTH_DEC) ||
          (item.day == '0) || (item.day > mlen);

    if ({1'b0, item.step} > 5'(gdad_pkg::MAX_STEP)) begin
      step = 5'(gdad_pkg::MAX_STEP);
    end else begin
      step = {1'b0, item.step};
    end

    sum  = {1'b0, item.day} + {1'b0, step};
    roll = (sum > {1'b0, mlen});

    res.day   = item.day;
    res.month = item.month;
    res.year  = item.year;
    res.ovf   = 1'b0;
    res.bad   = bad;

    if (!bad) begin
      if (roll) begin
        res.day = 5'(sum - {1'b0, mlen});
        if (item.month == gdad_pkg::MONTH_DEC) begin
          res.month = gdad_pkg::MONTH_JAN;
          res.year  = item.year + 12'd1;
          res.ovf   = (item.year == gdad_pkg::YEAR_MAX);
        end else begin
          res.month = item.month + 4'd1;
        end
      end else begin
        res.day = sum[4:0];
      end
    end
  end

endmodule

### rtl/gregorian_date_add_days.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_add_days: advance a Gregorian date by 0 to 15 days
// Datapath: an input register captures the accepted item, the date logic works on it,
// and a result register captures the outcome and drives out_valid.
// Throughput: one item per cycle outside reset; an input register and a result register
// bracket the single pass of date logic.
// Reset: synchronous active low; clears the valid bits, busy is high
// while reset is held. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module gregorian_date_add_days (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [gdad_pkg::DAY_W-1:0]    in_start_day,
  input  logic [gdad_pkg::MONTH_W-1:0]  in_start_month,
  input  logic [gdad_pkg::YEAR_W-1:0]   in_start_year,
  input  logic [gdad_pkg::STEP_W-1:0]   in_days_to_add,
  output logic                          out_valid,
  output logic [gdad_pkg::DAY_W-1:0]    out_end_day,
  output logic [gdad_pkg::MONTH_W-1:0]  out_end_month,
  output logic [gdad_pkg::YEAR_W-1:0]   out_end_year,
  output logic                          out_year_overflow,
  output logic                          out_date_invalid
);

  gdad_pkg::gdad_item_t item_r;
  logic                 item_vld_r;
  gdad_pkg::gdad_res_t  res_nxt;
  gdad_pkg::gdad_res_t  res_r;
  logic                 res_vld_r;
  logic                 accept;

  assign busy   = !rst_n;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= accept;
      res_vld_r  <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.day   <= in_start_day;
      item_r.month <= in_start_month;
      item_r.year  <= in_start_year;
      item_r.step  <= in_days_to_add;
    end
    if (item_vld_r) begin
      res_r <= res_nxt;
    end
  end

  gdad_calc u_calc (
    .item (item_r),
    .res  (res_nxt)
  );

  assign out_valid         = res_vld_r;
  assign out_end_day       = res_r.day;
  assign out_end_month     = res_r.month;
  assign out_end_year      = res_r.year;
  assign out_year_overflow = res_r.ovf;
  assign out_date_invalid  = res_r.bad;

endmodule

### rtl/gdad_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdad_chk: port level checks for the date advance block
// Latency, no spurious results, flag consistency, result range and pass-through of rejected dates.
// ----------------------------------------------------------------------------
module gdad_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [gdad_pkg::DAY_W-1:0]    in_start_day,
  input logic [gdad_pkg::MONTH_W-1:0]  in_start_month,
  input logic [gdad_pkg::YEAR_W-1:0]   in_start_year,
  input logic [gdad_pkg::STEP_W-1:0]   in_days_to_add,
  input logic                          out_valid,
  input logic [gdad_pkg::DAY_W-1:0]    out_end_day,
  input logic [gdad_pkg::MONTH_W-1:0]  out_end_month,
  input logic [gdad_pkg::YEAR_W-1:0]   out_end_year,
  input logic                          out_year_overflow,
  input logic                          out_date_invalid
);

  // every accepted item yields a result through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("missing result");

  // no result without an accepted item
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("spurious result");

  // overflow only lands on january of year zero of a valid date
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_year_overflow) |->
      (!out_date_invalid && out_end_year == '0 && out_end_month == gdad_pkg::MONTH_JAN))
    else $error("bad overflow result");

  // rejected date comes back unchanged
  a_invalid_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_date_invalid) |->
      (out_end_day == $past(in_start_day, 2) && out_end_month == $past(in_start_month, 2) &&
       out_end_year == $past(in_start_year, 2)))
    else $error("invalid date altered");

  // valid results have a day of 1 to 31 and a month of January to December
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_date_invalid) |->
      (out_end_day != '0 && out_end_month >= gdad_pkg::MONTH_JAN &&
       out_end_month <= gdad_pkg::MONTH_DEC && out_end_day <= 5'd31 &&
       $past(in_days_to_add, 2) <= 4'd15))
    else $error("result out of range");

endmodule

bind gregorian_date_add_days gdad_chk u_gdad_chk (.*);

### tb/sv/gregorian_date_add_days_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_add_days_tb: self-checking bench for the date advance block
// Drives directed and random dates through the start/busy port. A scoreboard
// computes each advanced date and compares it field by field, in order, with
// the out_valid strobes. The sender idles at several rates across phases.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_tb;

  import gdad_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned MAX_GAP     = 40;
  localparam int unsigned DRAIN_WAIT  = 8;

  class date_advance_sb;
    gdad_res_t   pending_dates[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function bit leap_year(logic [YEAR_W-1:0] y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function logic [DAY_W-1:0] days_in_month(logic [MONTH_W-1:0] m, logic [YEAR_W-1:0] y);
      case (m)
        MONTH_FEB: return leap_year(y) ? 5'd29 : 5'd28;
        MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 5'd30;
        default: return 5'd31;
      endcase
    endfunction

    function gdad_res_t advance_date(gdad_item_t it);
      gdad_res_t         r;
      logic [5:0]        len;
      logic [5:0]        sum;
      logic [STEP_W-1:0] step;
      r.day   = it.day;
      r.month = it.month;
      r.year  = it.year;
      r.ovf   = 1'b0;
      r.bad   = 1'b0;
      step = (it.step > MAX_STEP) ? STEP_W'(MAX_STEP) : it.step;
      len = days_in_month(it.month, it.year);
      if (it.month < MONTH_JAN || it.month > MONTH_DEC || it.day == 0 || it.day > len) begin
        r.bad = 1'b1;
      end else begin
        sum = it.day + step;
        if (sum > len) begin
          r.day = DAY_W'(sum - len);
          if (it.month == MONTH_DEC) begin
            r.month = MONTH_JAN;
            if (it.year == YEAR_MAX) begin
              r.year = '0;
              r.ovf  = 1'b1;
            end else begin
              r.year = it.year + 1'b1;
            end
          end else begin
            r.month = it.month + 1'b1;
          end
        end else begin
          r.day = DAY_W'(sum);
        end
      end
      return r;
    endfunction

    function void note_input(gdad_item_t it);
      pending_dates.push_back(advance_date(it));
    endfunction

    function void check_result(gdad_res_t got);
      gdad_res_t exp;
      if (pending_dates.size() == 0) begin
        $error("unexpected result: day %0d month %0d year %0d", got.day, got.month, got.year);
        errors++;
        return;
      end
      exp = pending_dates.pop_front();
      if (got.day !== exp.day) begin
        $error("end_day: expected %0d, got %0d", exp.day, got.day);
        errors++;
      end
      if (got.month !== exp.month) begin
        $error("end_month: expected %0d, got %0d", exp.month, got.month);
        errors++;
      end
      if (got.year !== exp.year) begin
        $error("end_year: expected %0d, got %0d", exp.year, got.year);
        errors++;
      end
      if (got.ovf !== exp.ovf) begin
        $error("year_overflow: expected %0d, got %0d", exp.ovf, got.ovf);
        errors++;
      end
      if (got.bad !== exp.bad) begin
        $error("date_invalid: expected %0d, got %0d", exp.bad, got.bad);
        errors++;
      end
    endfunction

    function int pending();
      return pending_dates.size();
    endfunction

    function void flag_leftovers();
      if (pending_dates.size() != 0) begin
        $error("%0d expected dates never came out", pending_dates.size());
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [DAY_W-1:0]    in_start_day;
  logic [MONTH_W-1:0]  in_start_month;
  logic [YEAR_W-1:0]   in_start_year;
  logic [STEP_W-1:0]   in_days_to_add;
  logic                out_valid;
  logic [DAY_W-1:0]    out_end_day;
  logic [MONTH_W-1:0]  out_end_month;
  logic [YEAR_W-1:0]   out_end_year;
  logic                out_year_overflow;
  logic                out_date_invalid;

  gdad_item_t     in_item;
  gdad_res_t      out_res;
  date_advance_sb sb;
  int unsigned    idle_cycles;
  int unsigned    sender_idle_pct;

  assign in_item = {in_start_day, in_start_month, in_start_year, in_days_to_add};
  assign out_res = {out_end_day, out_end_month, out_end_year, out_year_overflow,
                    out_date_invalid};

  gregorian_date_add_days dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_start_day      (in_start_day),
    .in_start_month    (in_start_month),
    .in_start_year     (in_start_year),
    .in_days_to_add    (in_days_to_add),
    .out_valid         (out_valid),
    .out_end_day       (out_end_day),
    .out_end_month     (out_end_month),
    .out_end_year      (out_end_year),
    .out_year_overflow (out_year_overflow),
    .out_date_invalid  (out_date_invalid)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // item and result monitor
  always @(posedge clk) begin
    if (rst_n === 1'b1 && start && busy === 1'b0) begin
      sb.note_input(in_item);
    end
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      sb.check_result(out_res);
    end
    if (rst_n === 1'b1 && ((start && busy === 1'b0) || out_valid === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    idle_cycles = 0;
    @(posedge clk);
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("gregorian_date_add_days_tb: done, errors");
    $finish;
  end

  task automatic send_date(logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                           logic [YEAR_W-1:0] y, logic [STEP_W-1:0] s);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99, 0) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      gap++;
    end
    start          <= 1'b1;
    in_start_day   <= d;
    in_start_month <= m;
    in_start_year  <= y;
    in_days_to_add <= s;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic drain_dates();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [YEAR_W-1:0] pick_year();
    case ($urandom_range(5, 0))
      0: return YEAR_MAX - YEAR_W'($urandom_range(1, 0));
      1: return YEAR_W'($urandom_range(40, 0) * 100);
      2: return YEAR_W'($urandom_range(10, 0) * 400);
      3: return YEAR_W'($urandom_range(1023, 0) * 4);
      default: return YEAR_W'($urandom);
    endcase
  endfunction

  task automatic send_random_date();
    logic [DAY_W-1:0]   d;
    logic [MONTH_W-1:0] m;
    logic [YEAR_W-1:0]  y;
    logic [STEP_W-1:0]  s;
    logic [DAY_W-1:0]   len;
    y = pick_year();
    s = STEP_W'($urandom_range(15, 0));
    if ($urandom_range(99, 0) < 12) begin
      // malformed dates: any day, any month code
      d = DAY_W'($urandom_range(31, 0));
      m = MONTH_W'($urandom_range(15, 0));
    end else begin
      m = MONTH_W'($urandom_range(MONTH_DEC, MONTH_JAN));
      len = sb.days_in_month(m, y);
      if ($urandom_range(1, 0) == 0) begin
        d = DAY_W'($urandom_range(len, 1));
      end else begin
        // near the month end so rollovers are common
        d = len - DAY_W'($urandom_range(14, 0));
      end
    end
    send_date(d, m, y, s);
  endtask

  task automatic run_random(int unsigned count, int unsigned idle_pct);
    sender_idle_pct = idle_pct;
    repeat (count) send_random_date();
  endtask

  initial begin
    sb = new();
    sender_idle_pct = 0;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_start_day   <= '0;
    in_start_month <= '0;
    in_start_year  <= '0;
    in_days_to_add <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed dates
    send_date(5'd1,  MONTH_JAN, 12'd0,    4'd0);
    send_date(5'd29, MONTH_FEB, 12'd0,    4'd0);
    send_date(5'd28, MONTH_FEB, 12'd1900, 4'd1);
    send_date(5'd29, MONTH_FEB, 12'd1900, 4'd0);
    send_date(5'd29, MONTH_FEB, 12'd2000, 4'd15);
    send_date(5'd28, MONTH_FEB, 12'd2024, 4'd1);
    send_date(5'd28, MONTH_FEB, 12'd2023, 4'd1);
    send_date(5'd31, MONTH_DEC, YEAR_MAX, 4'd1);
    send_date(5'd31, MONTH_DEC, YEAR_MAX, 4'd15);
    send_date(5'd31, MONTH_DEC, 12'd4094, 4'd1);
    send_date(5'd17, MONTH_DEC, 12'd2023, 4'd15);
    send_date(5'd0,  MONTH_JUN, 12'd2000, 4'd3);
    send_date(5'd31, MONTH_APR, 12'd2001, 4'd1);
    send_date(5'd31, MONTH_NOV, 12'd2001, 4'd0);
    send_date(5'd10, 4'd0,      12'd2000, 4'd2);
    send_date(5'd10, 4'd13,     12'd1999, 4'd5);
    send_date(5'd31, 4'd15,     YEAR_MAX, 4'd15);
    send_date(5'd30, MONTH_NOV, 12'd2001, 4'd15);
    send_date(5'd16, MONTH_SEP, 12'd1777, 4'd15);
    send_date(5'd31, MONTH_JAN, 12'd2001, 4'd15);
    send_date(5'd1,  MONTH_JAN, YEAR_MAX, 4'd15);
    send_date(5'd31, MONTH_DEC, 12'd0,    4'd0);
    drain_dates();

    // random phases: back to back, sparse sender, light idling
    run_random(200, 0);
    drain_dates();
    run_random(200, 82);
    drain_dates();
    run_random(250, 14);
    drain_dates();

    repeat (DRAIN_WAIT) @(posedge clk);
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("gregorian_date_add_days_tb: done, clean");
    end else begin
      $display("gregorian_date_add_days_tb: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/gdad_pkg.sv
rtl/gdad_calc.sv
rtl/gregorian_date_add_days.sv
rtl/gdad_chk.sv
tb/sv/gregorian_date_add_days_tb.sv
